### sv/dtg_pkg.sv
// ----------------------------------------------------------------------------
// dtg_pkg
// Shared constants, keypad grid, key decode and cosine table entry function.
// ----------------------------------------------------------------------------
`default_nettype none

package dtg_pkg;

  localparam int DEF_SAMPLE_RATE     = 8000;
  localparam int DEF_PHASE_BITS      = 16;
  localparam int DEF_TABLE_ADDR_BITS = 8;

  localparam int KEY_W    = 8;
  localparam int SAMPLE_W = 8;
  localparam int AMP_W    = 8;

  localparam logic [63:0] ROW_HZ [4] = '{64'd697, 64'd770, 64'd852, 64'd941};
  localparam logic [63:0] COL_HZ [4] = '{64'd1209, 64'd1336, 64'd1477, 64'd1633};

  localparam logic [KEY_W-1:0] GRID [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h44
  };

  localparam logic [SAMPLE_W-1:0] MIDSCALE = 8'd128;

  typedef struct packed {
    logic       hit;
    logic [1:0] row;
    logic [1:0] col;
  } key_hit_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } stage_t;

  function automatic key_hit_t key_lookup(input logic [KEY_W-1:0] key);
    key_hit_t res;
    res = '0;
    for (int i = 15; i >= 0; i--) begin
      if (GRID[i] == key) begin
        res.hit = 1'b1;
        res.row = 2'(i >> 2);
        res.col = 2'(i & 3);
      end
    end
    return res;
  endfunction

  // sin(pi/2*u), u and result in Q30
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] h;
    u2 = (u * u) >> 30;
    h  = 64'd172272;
    h  = 64'd5026996    - ((u2 * h) >> 30);
    h  = 64'd85569305   - ((u2 * h) >> 30);
    h  = 64'd693598669  - ((u2 * h) >> 30);
    h  = 64'd1686629713 - ((u2 * h) >> 30);
    return (u * h) >> 30;
  endfunction

  // round(64*cos(2*pi*k/2^abits)), evaluated at elaboration only
  function automatic logic signed [AMP_W-1:0] cos_entry(input int k, input int abits);
    logic [31:0] t;
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] mag;
    logic [63:0] m;
    t    = 32'(k) << (16 - abits);
    quad = t[15:14];
    r    = {34'd0, t[13:0], 16'd0};
    if (quad == 2'd0 || quad == 2'd2) begin
      mag = quarter_sine(64'd1073741824 - r);
    end else begin
      mag = quarter_sine(r);
    end
    m = (mag + 64'd8388608) >> 24;
    if (m > 64'd64) begin
      m = 64'd64;
    end
    if (quad == 2'd1 || quad == 2'd2) begin
      return -AMP_W'(m);
    end
    return AMP_W'(m);
  endfunction

endpackage

`default_nettype wire

### sv/dtg_phase.sv
// ----------------------------------------------------------------------------
// dtg_phase
// Key decode and the two phase accumulators; forms the cosine table addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_phase #(
  parameter int SAMPLE_RATE     = dtg_pkg::DEF_SAMPLE_RATE,
  parameter int PHASE_BITS      = dtg_pkg::DEF_PHASE_BITS,
  parameter int TABLE_ADDR_BITS = dtg_pkg::DEF_TABLE_ADDR_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [dtg_pkg::KEY_W-1:0]     key_i,
  input  wire logic                          restart_i,
  output      logic                          hit_o,
  output      logic [TABLE_ADDR_BITS-1:0]    row_addr_o,
  output      logic [TABLE_ADDR_BITS-1:0]    col_addr_o
);
  import dtg_pkg::*;

  localparam logic [63:0] HALF = 64'(SAMPLE_RATE / 2);
  localparam logic [63:0] RATE = 64'(SAMPLE_RATE);

  localparam logic [PHASE_BITS-1:0] ROW_INC [4] = '{
    PHASE_BITS'(((ROW_HZ[0] << PHASE_BITS) + HALF) / RATE),
    PHASE_BITS'(((ROW_HZ[1] << PHASE_BITS) + HALF) / RATE),
    PHASE_BITS'(((ROW_HZ[2] << PHASE_BITS) + HALF) / RATE),
    PHASE_BITS'(((ROW_HZ[3] << PHASE_BITS) + HALF) / RATE)
  };
  localparam logic [PHASE_BITS-1:0] COL_INC [4] = '{
    PHASE_BITS'(((COL_HZ[0] << PHASE_BITS) + HALF) / RATE),
    PHASE_BITS'(((COL_HZ[1] << PHASE_BITS) + HALF) / RATE),
    PHASE_BITS'(((COL_HZ[2] << PHASE_BITS) + HALF) / RATE),
    PHASE_BITS'(((COL_HZ[3] << PHASE_BITS) + HALF) / RATE)
  };

  logic [PHASE_BITS-1:0] row_phase_q, row_phase_d, row_base;
  logic [PHASE_BITS-1:0] col_phase_q, col_phase_d, col_base;
  key_hit_t              dec;

  always_comb begin
    dec      = key_lookup(key_i);
    row_base = restart_i ? '0 : row_phase_q;
    col_base = restart_i ? '0 : col_phase_q;
    row_phase_d = row_base + (dec.hit ? ROW_INC[dec.row] : '0);
    col_phase_d = col_base + (dec.hit ? COL_INC[dec.col] : '0);
  end

  assign hit_o      = dec.hit;
  assign row_addr_o = row_base[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign col_addr_o = col_base[PHASE_BITS-1 -: TABLE_ADDR_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_phase_q <= '0;
      col_phase_q <= '0;
    end else if (fire_i) begin
      row_phase_q <= row_phase_d;
      col_phase_q <= col_phase_d;
    end
  end

endmodule

`default_nettype wire

### sv/dtg_cos_rom.sv
// ----------------------------------------------------------------------------
// dtg_cos_rom
// Shared cosine table, two read ports with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_cos_rom #(
  parameter int TABLE_ADDR_BITS = dtg_pkg::DEF_TABLE_ADDR_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [TABLE_ADDR_BITS-1:0]        addr_a_i,
  input  wire logic [TABLE_ADDR_BITS-1:0]        addr_b_i,
  output      logic signed [dtg_pkg::AMP_W-1:0]  data_a_o,
  output      logic signed [dtg_pkg::AMP_W-1:0]  data_b_o
);
  import dtg_pkg::*;

  localparam int DEPTH = 1 << TABLE_ADDR_BITS;

  logic signed [AMP_W-1:0] rom [DEPTH];
  logic signed [AMP_W-1:0] data_a_q, data_b_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic signed [AMP_W-1:0] VAL = cos_entry(k, TABLE_ADDR_BITS);
    assign rom[k] = VAL;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= rom[addr_a_i];
      data_b_q <= rom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

### sv/dtg_mix.sv
// ----------------------------------------------------------------------------
// dtg_mix
// Table read stage control, tone sum with saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_mix (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                fire_i,
  input  wire logic                                hit_i,
  output      logic                                in_ready_o,
  input  wire logic signed [dtg_pkg::AMP_W-1:0]    row_amp_i,
  input  wire logic signed [dtg_pkg::AMP_W-1:0]    col_amp_i,
  output      logic                                m_tvalid_o,
  input  wire logic                                m_tready_i,
  output      logic [dtg_pkg::SAMPLE_W-1:0]        sample_o,
  output      logic                                key_valid_o
);
  import dtg_pkg::*;

  stage_t                 s1_q, s1_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]    sample_q, sample_d;
  logic                   kv_q, kv_d;
  logic                   out_free, s1_adv;
  logic signed [9:0]      sum;
  logic [SAMPLE_W-1:0]    sat_sample;

  assign sum = 10'sd128 + 10'(row_amp_i) + 10'(col_amp_i);

  dtg_sat u_sat (
    .sum_i   (sum),
    .sample_o(sat_sample)
  );

  always_comb begin
    out_free = !out_valid_q || m_tready_i;
    s1_adv   = s1_q.valid && out_free;
    in_ready_o = !s1_q.valid || out_free;

    s1_d = s1_q;
    if (fire_i) begin
      s1_d.valid = 1'b1;
      s1_d.hit   = hit_i;
    end else if (s1_adv) begin
      s1_d.valid = 1'b0;
    end

    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    kv_d        = kv_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
      kv_d        = s1_q.hit;
      if (!s1_q.hit) begin
        sample_d = MIDSCALE;
      end else begin
        sample_d = sat_sample;
      end
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= s1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    kv_q     <= kv_d;
  end

  assign m_tvalid_o  = out_valid_q;
  assign sample_o    = sample_q;
  assign key_valid_o = kv_q;

endmodule

`default_nettype wire

### sv/dtg_mix_top_note.sv
// ----------------------------------------------------------------------------
// dtg_sat
// Saturating clamp of a tone sum to the unsigned sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_sat (
  input  wire logic signed [9:0]                 sum_i,
  output      logic [dtg_pkg::SAMPLE_W-1:0]      sample_o
);
  import dtg_pkg::*;

  always_comb begin
    if (sum_i < 10'sd0) begin
      sample_o = '0;
    end else if (sum_i > 10'sd255) begin
      sample_o = 8'd255;
    end else begin
      sample_o = sum_i[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/dtmf_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// dtmf_tone_generator_unit
// DTMF dual tone generator, one 8-bit audio sample per input word.
// ----------------------------------------------------------------------------
// Input stream: one word per sample tick; tdata carries the ASCII key,
// tuser the restart flag (clears both tone phases before this sample).
// Output stream: one word per input word, in order; tdata is the unsigned
// sample (midscale 128), tuser is high when the key is in the keypad grid.
// An unknown key gives 128 with tuser low; only a restart changes the phases.
// Pipeline: the table read is registered at the accept edge, then the sum
// enters the mix register, which raises tvalid, once that one is free.
// Throughput: one word per cycle while the receiver takes the output; the
// phase accumulators update at accept; the cosine table read is registered.
// Reset clears both phases and empties the pipeline.
// When the receiver stalls, the output register and the table stage hold;
// the input keeps accepting until both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmf_tone_generator_unit #(
  parameter int SAMPLE_RATE     = dtg_pkg::DEF_SAMPLE_RATE,
  parameter int PHASE_BITS      = dtg_pkg::DEF_PHASE_BITS,
  parameter int TABLE_ADDR_BITS = dtg_pkg::DEF_TABLE_ADDR_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output      logic       s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] key_code
  input  wire logic       s_axis_tuser_i,   // [0] restart
  output      logic       m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output      logic [7:0] m_axis_tdata_o,   // [7:0] sample_out
  output      logic       m_axis_tuser_o    // [0] key_valid
);
  import dtg_pkg::*;

  logic                          fire;
  logic                          hit;
  logic [TABLE_ADDR_BITS-1:0]    row_addr, col_addr;
  logic signed [AMP_W-1:0]       row_amp, col_amp;
  logic [SAMPLE_W-1:0]           sample;

  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  dtg_phase #(
    .SAMPLE_RATE    (SAMPLE_RATE),
    .PHASE_BITS     (PHASE_BITS),
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .key_i     (s_axis_tdata_i),
    .restart_i (s_axis_tuser_i),
    .hit_o     (hit),
    .row_addr_o(row_addr),
    .col_addr_o(col_addr)
  );

  dtg_cos_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (fire),
    .addr_a_i(row_addr),
    .addr_b_i(col_addr),
    .data_a_o(row_amp),
    .data_b_o(col_amp)
  );

  dtg_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .hit_i      (hit),
    .in_ready_o (s_axis_tready_o),
    .row_amp_i  (row_amp),
    .col_amp_i  (col_amp),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sample_o   (sample),
    .key_valid_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = sample;

endmodule

`default_nettype wire

### dv/dtmf_sample_checker.sv
// ----------------------------------------------------------------------------
// dtmf_sample_checker
// Watches both streams of the DTMF tone generator, keeps its own model of the
// two tone oscillators and the cosine lookup, and compares every output word
// in order against the predicted sample and key flag.
// ----------------------------------------------------------------------------
module dtmf_sample_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tuser_i,
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,
  input  logic       m_tuser_i,
  output int         errors_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = dtg_pkg::DEF_PHASE_BITS;
  localparam int AB = dtg_pkg::DEF_TABLE_ADDR_BITS;
  localparam int SR = dtg_pkg::DEF_SAMPLE_RATE;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [dtg_pkg::SAMPLE_W-1:0] level;
    logic                         key_ok;
  } sample_t;

  localparam string KEYPAD = "123A456B789C*0#D";
  localparam int ROW_TONE [4] = '{697, 770, 852, 941};
  localparam int COL_TONE [4] = '{1209, 1336, 1477, 1633};
  // odd sine polynomial, highest order first (Horner)
  localparam u64_t SINE_POLY [5] = '{64'd172272, 64'd5026996, 64'd85569305,
                                     64'd693598669, 64'd1686629713};

  int            amp_lut [1<<AB];
  logic [PB-1:0] row_inc [4];
  logic [PB-1:0] col_inc [4];
  logic [PB-1:0] row_ph;
  logic [PB-1:0] col_ph;
  sample_t       sample_q [$];
  int            mismatches;

  function automatic logic [PB-1:0] phase_inc(input int hz);
    u64_t num;
    num = (u64_t'(hz) << PB) + u64_t'(SR / 2);
    return PB'(num / u64_t'(SR));
  endfunction

  // sin(pi/2 * u), Q30 in and out
  function automatic u64_t sine_q30(input u64_t u);
    u64_t sq;
    u64_t acc;
    sq  = (u * u) >> 30;
    acc = SINE_POLY[0];
    for (int k = 1; k < 5; k++) begin
      acc = SINE_POLY[k] - ((sq * acc) >> 30);
    end
    return (u * acc) >> 30;
  endfunction

  function automatic int cos_amp(input int addr);
    logic [15:0] turn;
    u64_t        frac;
    u64_t        mag;
    int          m;
    turn = 16'(addr << (16 - AB));
    frac = u64_t'(turn[13:0]) << 16;
    if (!turn[14]) begin
      mag = sine_q30(64'd1073741824 - frac);
    end else begin
      mag = sine_q30(frac);
    end
    m = int'((mag + 64'd8388608) >> 24);
    if (m > 64) begin
      m = 64;
    end
    return (turn[15] ^ turn[14]) ? -m : m;
  endfunction

  task automatic predict_sample(input logic [7:0] key, input logic restart);
    sample_t want;
    int      slot;
    int      lvl;
    slot = -1;
    if (restart) begin
      row_ph = '0;
      col_ph = '0;
    end
    for (int i = 15; i >= 0; i--) begin
      if (KEYPAD[i] == key) begin
        slot = i;
      end
    end
    if (slot < 0) begin
      want.level  = dtg_pkg::MIDSCALE;
      want.key_ok = 1'b0;
    end else begin
      lvl = 128 + amp_lut[row_ph >> (PB - AB)] + amp_lut[col_ph >> (PB - AB)];
      if (lvl < 0) begin
        lvl = 0;
      end
      if (lvl > 255) begin
        lvl = 255;
      end
      want.level  = 8'(lvl);
      want.key_ok = 1'b1;
      row_ph = row_ph + row_inc[slot >> 2];
      col_ph = col_ph + col_inc[slot & 3];
    end
    sample_q.push_back(want);
  endtask

  initial begin
    for (int a = 0; a < (1 << AB); a++) begin
      amp_lut[a] = cos_amp(a);
    end
    for (int i = 0; i < 4; i++) begin
      row_inc[i] = phase_inc(ROW_TONE[i]);
      col_inc[i] = phase_inc(COL_TONE[i]);
    end
    row_ph     = '0;
    col_ph     = '0;
    mismatches = 0;
    errors_o   = 0;
    pending_o  = 0;
    checked_o  = 0;
  end

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        predict_sample(s_tdata_i, s_tuser_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (sample_q.size() == 0) begin
          errors_o++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected output word: level %0d key_ok %0b", m_tdata_i, m_tuser_i);
          end
        end else begin
          want = sample_q.pop_front();
          if (m_tdata_i !== want.level || m_tuser_i !== want.key_ok) begin
            errors_o++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("sample %0d mismatch: expected level %0d key_ok %0b, got level %0d key_ok %0b",
                       checked_o, want.level, want.key_ok, m_tdata_i, m_tuser_i);
            end
          end
          checked_o++;
        end
      end
      pending_o = sample_q.size();
    end
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives keypad words into the DTMF tone generator: a directed opening over
// all keys, restarts and odd bytes, then tone bursts, silence and noise under
// four pacing phases with two long output stalls. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    LIMIT_CYCLES = 200000;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    PHASE_WORDS  = 400;
  localparam string KEYS         = "123A456B789C*0#D";

  logic       clk_i;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tuser;

  int errors;
  int pending;
  int checked;
  int cycles;
  int src_idle;
  int snk_stall;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int n_keyed;
  int n_restart;

  dtmf_tone_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  dtmf_sample_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      m_tready  <= 1'b0;
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  function automatic bit is_key(input logic [7:0] key);
    for (int i = 0; i < 16; i++) begin
      if (KEYS[i] == key) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // called and returns at a falling edge
  task automatic put_word(input logic [7:0] key, input logic restart);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= restart;
    do @(posedge clk_i); while (!s_tready);
    if (is_key(key)) begin
      n_keyed++;
    end
    if (restart) begin
      n_restart++;
    end
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input bit squeeze);
    int         sent;
    int         run_len;
    int         kind;
    bit         squeezed;
    logic [7:0] key;
    sent      = 0;
    squeezed  = 1'b0;
    src_idle  = src_pct;
    snk_stall = snk_pct;
    while (sent < PHASE_WORDS) begin
      if (squeeze && !squeezed && sent >= PHASE_WORDS / 3) begin
        hold_reqs++;
        squeezed = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        // tone burst: one key held, usually starting from a restart
        key     = KEYS[$urandom_range(15)];
        run_len = $urandom_range(40, 1);
        for (int i = 0; i < run_len && sent < PHASE_WORDS; i++) begin
          put_word(key, (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(49) == 0));
          sent++;
        end
      end else if (kind < 85) begin
        run_len = $urandom_range(12, 1);
        for (int i = 0; i < run_len && sent < PHASE_WORDS; i++) begin
          put_word(8'($urandom_range(255)), $urandom_range(9) == 0);
          sent++;
        end
      end else begin
        put_word(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    cycles    = 0;
    src_idle  = 0;
    snk_stall = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    n_keyed   = 0;
    n_restart = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // every key once, first from a restart (both peaks, clipped to 255)
    for (int i = 0; i < 16; i++) begin
      put_word(KEYS[i], i == 0);
    end
    put_word(8'h00, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'h7F, 1'b1);   // unknown key still clears phases
    put_word("5", 1'b0);
    put_word(8'h80, 1'b1);
    put_word("D", 1'b1);
    put_word("#", 1'b0);

    run_phase(0, 0, 1'b1);
    run_phase(70, 0, 1'b0);
    run_phase(0, 70, 1'b0);
    run_phase(26, 26, 1'b1);
    s_tvalid <= 1'b0;

    while (pending != 0 || hold_left != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d samples checked (%0d keypad words, %0d restarts), all keys and odd bytes,",
             checked, n_keyed, n_restart);
    $display("four pacing phases with two %0d-cycle output hold-offs.", HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/dtg_pkg.sv
sv/dtg_phase.sv
sv/dtg_cos_rom.sv
sv/dtg_mix.sv
sv/dtg_mix_top_note.sv
sv/dtmf_tone_generator_unit.sv
dv/dtmf_sample_checker.sv
dv/tb.sv
